// ----- hdl/vn_pkg.sv -----
// Shared constants and types for the 3D vector normalizer.
package vn_pkg;

  localparam int COMP_WIDTH = 16;
  localparam int MAG_W      = COMP_WIDTH;
  localparam int SQ_W       = 2 * COMP_WIDTH + 2;   // sum of three squares
  localparam int FRAC_W     = 28;                   // radicand scale 2^28
  localparam int RAD_W      = SQ_W + FRAC_W;
  localparam int ROOT_W     = RAD_W / 2;
  localparam int REM_W      = ROOT_W + 2;
  localparam int QUO_W      = 15;                   // quotient never exceeds 16385
  localparam int PRE_W      = FRAC_W - QUO_W;
  localparam int OUT_W      = 16;
  localparam int UNIT_ONE   = 16384;
  localparam int NUM_LANES  = 3;

  typedef struct packed {
    logic [NUM_LANES-1:0][MAG_W-1:0] mag;
    logic [NUM_LANES-1:0]            neg;
    logic                            zero;
  } sqrt_side_t;

  typedef struct packed {
    logic [ROOT_W-1:0] rem;
    logic [QUO_W-1:0]  lq;    // low dividend bits out, quotient bits in
  } div_lane_t;

  typedef struct packed {
    logic [NUM_LANES-1:0] neg;
    logic                 zero;
    logic [ROOT_W-1:0]    len;
  } div_side_t;

endpackage

// ----- hdl/vn_sqrt_step.sv -----
// One stage of the digit-by-digit integer square root.
module vn_sqrt_step
  import vn_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [RAD_W-1:0]  rad_i,
  input  logic [REM_W-1:0]  rem_i,
  input  logic [ROOT_W-1:0] root_i,
  input  sqrt_side_t        side_i,
  output logic              valid_o,
  output logic [RAD_W-1:0]  rad_o,
  output logic [REM_W-1:0]  rem_o,
  output logic [ROOT_W-1:0] root_o,
  output sqrt_side_t        side_o
);

  logic              valid_q;
  logic [RAD_W-1:0]  rad_q, rad_d;
  logic [REM_W-1:0]  rem_q, rem_d, rem_sh, trial;
  logic [ROOT_W-1:0] root_q, root_d;
  sqrt_side_t        side_q;
  logic              take;

  always_comb begin
    rem_sh = {rem_i[REM_W-3:0], rad_i[RAD_W-1:RAD_W-2]};
    trial  = {root_i, 2'b01};
    take   = (rem_sh >= trial);
    rem_d  = take ? (rem_sh - trial) : rem_sh;
    root_d = {root_i[ROOT_W-2:0], take};
    rad_d  = {rad_i[RAD_W-3:0], 2'b00};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q  <= rad_d;
      rem_q  <= rem_d;
      root_q <= root_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign rad_o   = rad_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;
  assign side_o  = side_q;

endmodule

// ----- hdl/vn_div_step.sv -----
// One restoring-division step for all three components against the length.
module vn_div_step
  import vn_pkg::*;
(
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  div_lane_t [NUM_LANES-1:0]      lane_i,
  input  div_side_t                      side_i,
  output logic                           valid_o,
  output div_lane_t [NUM_LANES-1:0]      lane_o,
  output div_side_t                      side_o
);

  logic                      valid_q;
  div_lane_t [NUM_LANES-1:0] lane_q, lane_d;
  div_side_t                 side_q;
  logic [ROOT_W:0]           rsh [NUM_LANES];
  logic [NUM_LANES-1:0]      ge;

  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      rsh[i] = {lane_i[i].rem, lane_i[i].lq[QUO_W-1]};
      ge[i]  = (rsh[i] >= {1'b0, side_i.len});
      lane_d[i].rem = ge[i] ? ROOT_W'(rsh[i] - {1'b0, side_i.len}) : rsh[i][ROOT_W-1:0];
      lane_d[i].lq  = {lane_i[i].lq[QUO_W-2:0], ge[i]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign lane_o  = lane_q;
  assign side_o  = side_q;

endmodule

// ----- hdl/vector3_normalize_top.sv -----
// Top level of the 3D vector normalizer: Q8.8 vector in, Q2.14 unit vector out.
//
// Fully pipelined: one vector per cycle while the output is not stalled. Three
// front stages form magnitudes, squares and their sum; the root is one bit per
// stage over ROOT_W stages; the three quotients are one bit per stage over 15
// stages; a final stage saturates to +-16384 and applies the sign. A stall on
// the output freezes the whole pipe; in_ready_o is low only while a result
// waits to be taken.
module vector3_normalize_top
  import vn_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [MAG_W-1:0] comp_x_i,
  input  logic signed [MAG_W-1:0] comp_y_i,
  input  logic signed [MAG_W-1:0] comp_z_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [OUT_W-1:0] unit_x_o,
  output logic signed [OUT_W-1:0] unit_y_o,
  output logic signed [OUT_W-1:0] unit_z_o,
  output logic                    zero_vector_o
);

  logic adv;
  logic [NUM_LANES-1:0][MAG_W-1:0] comp;

  // front stages
  logic                              v1_q, v2_q, v3_q;
  logic [NUM_LANES-1:0][MAG_W-1:0]   mag1_q, mag2_q, mag3_q;
  logic [NUM_LANES-1:0]              neg1_q, neg2_q, neg3_q;
  logic [NUM_LANES-1:0][2*MAG_W-1:0] sq2_q;
  logic [SQ_W-1:0]                   sum3_q;

  // root chain
  logic              sv   [ROOT_W+1];
  logic [RAD_W-1:0]  srad [ROOT_W+1];
  logic [REM_W-1:0]  srem [ROOT_W+1];
  logic [ROOT_W-1:0] sroot[ROOT_W+1];
  sqrt_side_t        sside[ROOT_W+1];

  // divide chain
  logic                      dv   [QUO_W+1];
  div_lane_t [NUM_LANES-1:0] dlane[QUO_W+1];
  div_side_t                 dside[QUO_W+1];

  logic                            out_valid_q;
  logic [NUM_LANES-1:0][OUT_W-1:0] unit_q, unit_d;
  logic                            zero_q;
  logic [QUO_W-1:0]                sat;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;
  assign comp       = {comp_z_i, comp_y_i, comp_x_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < NUM_LANES; i++) begin
        neg1_q[i] <= comp[i][MAG_W-1];
        mag1_q[i] <= comp[i][MAG_W-1] ? (~comp[i] + MAG_W'(1)) : comp[i];
        sq2_q[i]  <= mag1_q[i] * mag1_q[i];
      end
      mag2_q <= mag1_q;
      neg2_q <= neg1_q;
      sum3_q <= SQ_W'(sq2_q[0]) + SQ_W'(sq2_q[1]) + SQ_W'(sq2_q[2]);
      mag3_q <= mag2_q;
      neg3_q <= neg2_q;
    end
  end

  assign sv[0]         = v3_q;
  assign srad[0]       = {sum3_q, {FRAC_W{1'b0}}};
  assign srem[0]       = '0;
  assign sroot[0]      = '0;
  assign sside[0].mag  = mag3_q;
  assign sside[0].neg  = neg3_q;
  assign sside[0].zero = (sum3_q == '0);

  for (genvar s = 0; s < ROOT_W; s++) begin : g_root
    vn_sqrt_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (sv[s]),
      .rad_i   (srad[s]),
      .rem_i   (srem[s]),
      .root_i  (sroot[s]),
      .side_i  (sside[s]),
      .valid_o (sv[s+1]),
      .rad_o   (srad[s+1]),
      .rem_o   (srem[s+1]),
      .root_o  (sroot[s+1]),
      .side_o  (sside[s+1])
    );
  end

  // Dividend is |c| * 2^28; its top bits seed the partial remainder.
  assign dv[0]         = sv[ROOT_W];
  assign dside[0].neg  = sside[ROOT_W].neg;
  assign dside[0].zero = sside[ROOT_W].zero;
  assign dside[0].len  = sroot[ROOT_W];
  for (genvar l = 0; l < NUM_LANES; l++) begin : g_seed
    assign dlane[0][l].rem = {{(ROOT_W-MAG_W-PRE_W){1'b0}}, sside[ROOT_W].mag[l],
                              {PRE_W{1'b0}}};
    assign dlane[0][l].lq  = '0;
  end

  for (genvar s = 0; s < QUO_W; s++) begin : g_div
    vn_div_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (dv[s]),
      .lane_i  (dlane[s]),
      .side_i  (dside[s]),
      .valid_o (dv[s+1]),
      .lane_o  (dlane[s+1]),
      .side_o  (dside[s+1])
    );
  end

  always_comb begin
    sat = '0;
    for (int i = 0; i < NUM_LANES; i++) begin
      sat = (dlane[QUO_W][i].lq > QUO_W'(UNIT_ONE)) ? QUO_W'(UNIT_ONE)
                                                    : dlane[QUO_W][i].lq;
      if (dside[QUO_W].zero) begin
        unit_d[i] = '0;
      end else if (dside[QUO_W].neg[i]) begin
        unit_d[i] = -OUT_W'(sat);
      end else begin
        unit_d[i] = OUT_W'(sat);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= dv[QUO_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      unit_q <= unit_d;
      zero_q <= dside[QUO_W].zero;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign unit_x_o      = unit_q[0];
  assign unit_y_o      = unit_q[1];
  assign unit_z_o      = unit_q[2];
  assign zero_vector_o = zero_q;

  a_zero_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_vector_o |->
      unit_x_o == '0 && unit_y_o == '0 && unit_z_o == '0)
    else $error("zero vector with nonzero components");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      unit_x_o <= OUT_W'(UNIT_ONE) && unit_x_o >= -OUT_W'(UNIT_ONE) &&
      unit_y_o <= OUT_W'(UNIT_ONE) && unit_y_o >= -OUT_W'(UNIT_ONE) &&
      unit_z_o <= OUT_W'(UNIT_ONE) && unit_z_o >= -OUT_W'(UNIT_ONE))
    else $error("component outside unit range");

  a_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !zero_vector_o |->
      unit_x_o != '0 || unit_y_o != '0 || unit_z_o != '0)
    else $error("nonzero vector normalized to zero");

endmodule
